### hw/rtl/rtyc_pkg.sv
// Shared types, constants and coefficient helper for the RGB to YUV chroma subsampler.
// No dependencies.
package rtyc_pkg;

	localparam int MAX_WIDTH_DEF      = 2048;
	localparam int COEF_FRAC_BITS_DEF = 16;
	localparam int ROW_LIMIT          = 4096;
	localparam int ROW_W              = 12;
	localparam int GSUM_W             = 10;
	localparam int CFG_DATA_W         = 13;
	localparam int CFG_IDX_W          = 2;

	typedef struct packed {
		logic [7:0] y;
		logic [7:0] u;
		logic [7:0] v;
	} yuv_t;

	// coef * 1e-5 scaled by 2^frac, halves rounded away from zero (k > 0)
	function automatic longint coef(input longint k, input int frac);
		return ((k <<< frac) + 64'sd50000) / 64'sd100000;
	endfunction

endpackage

### hw/rtl/rtyc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rtyc_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 2048
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/rtyc_csc.sv
// Color space conversion: RGB to clamped Y, U+128, V+128 with fixed-point coefficients.
// Depends on rtyc_pkg.
module rtyc_csc #(
	parameter int COEF_FRAC_BITS = rtyc_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic [7:0]   red,
	input  logic [7:0]   green,
	input  logic [7:0]   blue,
	output rtyc_pkg::yuv_t yuv
);
	import rtyc_pkg::*;

	localparam int SW = COEF_FRAC_BITS + 12;

	localparam logic signed [SW-1:0] CY_R = SW'(coef(29900, COEF_FRAC_BITS));
	localparam logic signed [SW-1:0] CY_G = SW'(coef(58700, COEF_FRAC_BITS));
	localparam logic signed [SW-1:0] CY_B = SW'(coef(11400, COEF_FRAC_BITS));
	localparam logic signed [SW-1:0] CU_R = SW'(-coef(14713, COEF_FRAC_BITS));
	localparam logic signed [SW-1:0] CU_G = SW'(-coef(28886, COEF_FRAC_BITS));
	localparam logic signed [SW-1:0] CU_B = SW'(coef(43600, COEF_FRAC_BITS));
	localparam logic signed [SW-1:0] CV_R = SW'(coef(61500, COEF_FRAC_BITS));
	localparam logic signed [SW-1:0] CV_G = SW'(-coef(51499, COEF_FRAC_BITS));
	localparam logic signed [SW-1:0] CV_B = SW'(-coef(10001, COEF_FRAC_BITS));

	function automatic logic [7:0] clamp8(input logic signed [11:0] val);
		if (val < 12'sd0) begin
			return 8'd0;
		end else if (val > 12'sd255) begin
			return 8'd255;
		end
		return val[7:0];
	endfunction

	logic signed [SW-1:0] rx, gx, bx;
	logic signed [SW-1:0] sy, su, sv;
	logic signed [SW-1:0] fy, fu, fv;

	assign rx = $signed({{(SW-8){1'b0}}, red});
	assign gx = $signed({{(SW-8){1'b0}}, green});
	assign bx = $signed({{(SW-8){1'b0}}, blue});

	assign sy = CY_R * rx + CY_G * gx + CY_B * bx;
	assign su = CU_R * rx + CU_G * gx + CU_B * bx;
	assign sv = CV_R * rx + CV_G * gx + CV_B * bx;

	// arithmetic shift floors
	assign fy = sy >>> COEF_FRAC_BITS;
	assign fu = su >>> COEF_FRAC_BITS;
	assign fv = sv >>> COEF_FRAC_BITS;

	assign yuv.y = clamp8(fy[11:0]);
	assign yuv.u = clamp8(fu[11:0] + 12'sd128);
	assign yuv.v = clamp8(fv[11:0] + 12'sd128);

endmodule

### hw/rtl/rgb_to_yuv_chroma_subsampler_top.sv
// Usage notes:
// Input channel in_valid/in_ready carries one RGB pixel (red, green, blue) per word,
// in raster order. Output channel out_valid/out_ready returns exactly one word per
// pixel: luma, chroma_valid with blue_diff/red_diff (zero when no chroma pair
// completes on that pixel), row_end and frame_end.
// Configuration: write_enable, reg_index, write_data; index 0 chroma_mode,
// 1 image_width, 2 image_height. Write only while no pixel is in flight.
// Path: an accepted pixel is registered in stage 1, then in stage 2, then in the output register.
// Throughput: one pixel per cycle while out_ready stays high. Every stage is a single register
// pass; the line buffer does one read and one write per cycle.
// Line buffer: MAX_WIDTH entries of U/V group sums from even rows, read back on
// odd rows in the two-row modes; it is not cleared and needs no init pass.
// Reset (arst_n low): pipeline empties, counters and group sums clear, config
// returns to 444, 640 x 480.
// Stall: when out_ready is low the three stages fill and in_ready drops once the
// pipeline is full; no word is lost or repeated.
// Depends on rtyc_pkg, rtyc_csc, rtyc_ram.
module rgb_to_yuv_chroma_subsampler_top #(
	parameter int MAX_WIDTH      = rtyc_pkg::MAX_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = rtyc_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               write_enable,
	input  logic [rtyc_pkg::CFG_IDX_W-1:0]     reg_index,
	input  logic [rtyc_pkg::CFG_DATA_W-1:0]    write_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [7:0]                         red,
	input  logic [7:0]                         green,
	input  logic [7:0]                         blue,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [7:0]                         luma,
	output logic                               chroma_valid,
	output logic [7:0]                         blue_diff,
	output logic [7:0]                         red_diff,
	output logic                               row_end,
	output logic                               frame_end
);
	import rtyc_pkg::*;

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WX = ((CW > 12) ? CW : 12) + 1;
	localparam int LW = 2 * GSUM_W;

	localparam logic [CFG_IDX_W-1:0] REG_MODE   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(2);

	typedef enum logic [2:0] {
		MODE_444 = 3'd0,
		MODE_440 = 3'd1,
		MODE_422 = 3'd2,
		MODE_420 = 3'd3,
		MODE_411 = 3'd4,
		MODE_410 = 3'd5
	} chroma_mode_t;

	typedef struct packed {
		logic          grp_last;
		logic          two_rows;
		logic          odd_row;
		logic [1:0]    hs;
		logic [CW-1:0] idx;
		logic          row_end;
		logic          frame_end;
	} ctrl_t;

	// configuration
	logic [2:0]  chroma_mode_q;
	logic [11:0] image_width_q;
	logic [12:0] image_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chroma_mode_q  <= MODE_444;
			image_width_q  <= 12'd640;
			image_height_q <= 13'd480;
		end else if (write_enable) begin
			case (reg_index)
				REG_MODE:   chroma_mode_q  <= write_data[2:0];
				REG_WIDTH:  image_width_q  <= write_data[11:0];
				REG_HEIGHT: image_height_q <= write_data[12:0];
				default: ;
			endcase
		end
	end

	// size limits
	logic [WX-1:0]    wcfg, wm1_x;
	logic [CW-1:0]    wm1;
	logic [12:0]      hm1_x;
	logic [ROW_W-1:0] hm1;

	always_comb begin
		wcfg = WX'(image_width_q);
		if (wcfg == '0) begin
			wm1_x = '0;
		end else if (wcfg > WX'(MAX_WIDTH)) begin
			wm1_x = WX'(MAX_WIDTH - 1);
		end else begin
			wm1_x = wcfg - WX'(1);
		end
		wm1 = wm1_x[CW-1:0];
		if (image_height_q == 13'd0) begin
			hm1_x = 13'd0;
		end else if (image_height_q > 13'(ROW_LIMIT)) begin
			hm1_x = 13'(ROW_LIMIT - 1);
		end else begin
			hm1_x = image_height_q - 13'd1;
		end
		hm1 = hm1_x[ROW_W-1:0];
	end

	// pipeline handshake
	logic v_s1, v_s2;
	logic adv1, adv2, acc;

	assign adv2     = !out_valid || out_ready;
	assign adv1     = !v_s2 || adv2;
	assign in_ready = !v_s1 || adv1;
	assign acc      = in_valid && in_ready;

	// position counters and control decode at accept
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	ctrl_t            ctrl_a;

	always_comb begin
		ctrl_a = '0;
		case (chroma_mode_q)
			MODE_440: begin ctrl_a.hs = 2'd0; ctrl_a.two_rows = 1'b1; end
			MODE_422: begin ctrl_a.hs = 2'd1; ctrl_a.two_rows = 1'b0; end
			MODE_420: begin ctrl_a.hs = 2'd1; ctrl_a.two_rows = 1'b1; end
			MODE_411: begin ctrl_a.hs = 2'd2; ctrl_a.two_rows = 1'b0; end
			MODE_410: begin ctrl_a.hs = 2'd2; ctrl_a.two_rows = 1'b1; end
			default:  begin ctrl_a.hs = 2'd0; ctrl_a.two_rows = 1'b0; end
		endcase
		case (ctrl_a.hs)
			2'd1:    ctrl_a.grp_last = col_q[0];
			2'd2:    ctrl_a.grp_last = col_q[0] && col_q[1];
			default: ctrl_a.grp_last = 1'b1;
		endcase
		ctrl_a.odd_row   = row_q[0];
		ctrl_a.idx       = col_q >> ctrl_a.hs;
		ctrl_a.row_end   = col_q >= wm1;
		ctrl_a.frame_end = ctrl_a.row_end && (row_q >= hm1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (ctrl_a.row_end) begin
				col_q <= '0;
				row_q <= ctrl_a.frame_end ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// stage 1: pixel and control
	logic [7:0] red_s1, green_s1, blue_s1;
	ctrl_t      ctrl_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
			ctrl_s1  <= ctrl_a;
		end
	end

	yuv_t yuv_c;

	rtyc_csc #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_csc (
		.red  (red_s1),
		.green(green_s1),
		.blue (blue_s1),
		.yuv  (yuv_c)
	);

	// line buffer of upper-row group sums
	logic          mv1, mv2;
	logic          ram_we, ram_re, byp_hit;
	logic [LW-1:0] ram_wdata, ram_rdata;
	yuv_t          yuv_s2;
	ctrl_t         ctrl_s2;
	logic          byp_s2;
	logic [LW-1:0] byp_data_s2;

	assign mv1 = v_s1 && adv1;
	assign mv2 = v_s2 && adv2;

	assign ram_re  = mv1 && ctrl_s1.grp_last && ctrl_s1.two_rows && ctrl_s1.odd_row;
	assign ram_we  = mv2 && ctrl_s2.grp_last && ctrl_s2.two_rows && !ctrl_s2.odd_row;
	assign byp_hit = ram_re && ram_we && (ctrl_s1.idx == ctrl_s2.idx);

	rtyc_ram #(
		.WIDTH(LW),
		.DEPTH(MAX_WIDTH)
	) u_line_buf (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ctrl_s2.idx),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ctrl_s1.idx),
		.rdata(ram_rdata)
	);

	// stage 2: converted pixel, group accumulation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv1) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (mv1) begin
			yuv_s2      <= yuv_c;
			ctrl_s2     <= ctrl_s1;
			byp_s2      <= byp_hit;
			byp_data_s2 <= ram_wdata;
		end
	end

	logic [GSUM_W-1:0] grp_u_q, grp_v_q;
	logic [GSUM_W-1:0] gu, gv, bd10, rd10;
	logic [LW-1:0]     upper;
	logic [GSUM_W:0]   su11, sv11, bd11, rd11;
	logic [2:0]        sh2;
	logic              cv_c;
	logic [7:0]        bd_c, rd_c;

	assign gu        = grp_u_q + GSUM_W'(yuv_s2.u);
	assign gv        = grp_v_q + GSUM_W'(yuv_s2.v);
	assign ram_wdata = {gv, gu};
	assign upper     = byp_s2 ? byp_data_s2 : ram_rdata;
	assign su11      = (GSUM_W+1)'(upper[GSUM_W-1:0]) + (GSUM_W+1)'(gu);
	assign sv11      = (GSUM_W+1)'(upper[LW-1:GSUM_W]) + (GSUM_W+1)'(gv);
	assign sh2       = {1'b0, ctrl_s2.hs} + 3'd1;
	assign bd10      = gu >> ctrl_s2.hs;
	assign rd10      = gv >> ctrl_s2.hs;
	assign bd11      = su11 >> sh2;
	assign rd11      = sv11 >> sh2;

	always_comb begin
		cv_c = 1'b0;
		bd_c = 8'd0;
		rd_c = 8'd0;
		if (ctrl_s2.grp_last) begin
			if (!ctrl_s2.two_rows) begin
				cv_c = 1'b1;
				bd_c = bd10[7:0];
				rd_c = rd10[7:0];
			end else if (ctrl_s2.odd_row) begin
				cv_c = 1'b1;
				bd_c = bd11[7:0];
				rd_c = rd11[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_u_q <= '0;
			grp_v_q <= '0;
		end else if (mv2) begin
			if (ctrl_s2.grp_last || ctrl_s2.row_end) begin
				grp_u_q <= '0;
				grp_v_q <= '0;
			end else begin
				grp_u_q <= gu;
				grp_v_q <= gv;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv2) begin
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (mv2) begin
			luma         <= yuv_s2.y;
			chroma_valid <= cv_c;
			blue_diff    <= bd_c;
			red_diff     <= rd_c;
			row_end      <= ctrl_s2.row_end;
			frame_end    <= ctrl_s2.frame_end;
		end
	end

	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output register");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> v_s1)
		else $error("accepted pixel missing from stage 1");

	a_bypass_on_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_re && ram_we && (ctrl_s1.idx == ctrl_s2.idx)) |=> byp_s2)
		else $error("line buffer read-during-write not bypassed");

	a_frame_end_is_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_end) |-> row_end)
		else $error("frame end without row end");

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for rgb_to_yuv_chroma_subsampler_top: random and directed pixel
// frames in every chroma mode, predicted words compared field by field at the output.
// Depends on rtyc_pkg and the RTL of the block.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rtyc_pkg::*;

	localparam int PIX_MAX_WIDTH = MAX_WIDTH_DEF;
	localparam int COEF_FRAC     = COEF_FRAC_BITS_DEF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHROMA_MODE,
		REG_IMAGE_WIDTH,
		REG_IMAGE_HEIGHT
	} cfg_reg_e;

	typedef enum logic [2:0] {
		MODE_444, MODE_440, MODE_422, MODE_420, MODE_411, MODE_410, MODE_RSVD_6, MODE_RSVD_7
	} chroma_mode_e;

	typedef struct packed {
		logic [7:0] luma;
		logic       chroma;
		logic [7:0] cb;
		logic [7:0] cr;
		logic       row_last;
		logic       frame_last;
	} yuv_word_t;

	// coefficient given in units of 1e-5, rounded half away from zero
	function automatic longint fixed_coef(input longint units_e5);
		return ((units_e5 * (longint'(1) <<< COEF_FRAC)) + 50000) / 100000;
	endfunction

	localparam longint KY_R = fixed_coef(29900);
	localparam longint KY_G = fixed_coef(58700);
	localparam longint KY_B = fixed_coef(11400);
	localparam longint KU_R = -fixed_coef(14713);
	localparam longint KU_G = -fixed_coef(28886);
	localparam longint KU_B = fixed_coef(43600);
	localparam longint KV_R = fixed_coef(61500);
	localparam longint KV_G = -fixed_coef(51499);
	localparam longint KV_B = -fixed_coef(10001);

	localparam logic [23:0] PROBE_COLORS [11] = '{
		24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
		24'h00FFFF, 24'hFF00FF, 24'h808080, 24'h010101, 24'hFEFEFE
	};

	localparam chroma_mode_e ALL_MODES [8] = '{
		MODE_444, MODE_440, MODE_422, MODE_420, MODE_411, MODE_410, MODE_RSVD_6, MODE_RSVD_7
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  write_enable = 1'b0;
	logic [CFG_IDX_W-1:0]  reg_index = '0;
	logic [CFG_DATA_W-1:0] write_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [7:0]            red = '0;
	logic [7:0]            green = '0;
	logic [7:0]            blue = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [7:0]            luma;
	logic                  chroma_valid;
	logic [7:0]            blue_diff;
	logic [7:0]            red_diff;
	logic                  row_end;
	logic                  frame_end;

	// predictor state
	chroma_mode_e cfg_mode = MODE_444;
	logic [11:0]  cfg_width = 12'd640;
	logic [12:0]  cfg_height = 13'd480;
	int           pred_col = 0;
	int           pred_row = 0;
	logic [9:0]   grp_u = '0;
	logic [9:0]   grp_v = '0;
	logic [19:0]  upper_sums [PIX_MAX_WIDTH];

	yuv_word_t expected_words [$];
	int        errors = 0;
	int        pixels_sent = 0;
	int        src_idle_pct = 0;
	int        sink_idle_pct = 0;
	int        hold_off_left = 0;

	rgb_to_yuv_chroma_subsampler_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.write_enable (write_enable),
		.reg_index    (reg_index),
		.write_data   (write_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.luma         (luma),
		.chroma_valid (chroma_valid),
		.blue_diff    (blue_diff),
		.red_diff     (red_diff),
		.row_end      (row_end),
		.frame_end    (frame_end)
	);

	always #5 clk = ~clk;

	function automatic logic [7:0] clamp_byte(input longint v);
		if (v < 0)
			return 8'h00;
		if (v > 255)
			return 8'hFF;
		return v[7:0];
	endfunction

	function automatic logic [7:0] pick_level();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic predict_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		longint     rr, gg, bb;
		logic [7:0] u8, v8;
		logic [9:0] gu, gv;
		logic [10:0] pair_u, pair_v;
		logic [19:0] upper;
		int         hs, w, h, mask, idx;
		bit         two_rows;
		yuv_word_t  word;
		rr = r;
		gg = g;
		bb = b;
		word = '0;
		word.luma = clamp_byte((KY_R * rr + KY_G * gg + KY_B * bb) >>> COEF_FRAC);
		u8 = clamp_byte(((KU_R * rr + KU_G * gg + KU_B * bb) >>> COEF_FRAC) + 128);
		v8 = clamp_byte(((KV_R * rr + KV_G * gg + KV_B * bb) >>> COEF_FRAC) + 128);
		case (cfg_mode)
			MODE_440: begin hs = 0; two_rows = 1'b1; end
			MODE_422: begin hs = 1; two_rows = 1'b0; end
			MODE_420: begin hs = 1; two_rows = 1'b1; end
			MODE_411: begin hs = 2; two_rows = 1'b0; end
			MODE_410: begin hs = 2; two_rows = 1'b1; end
			default:  begin hs = 0; two_rows = 1'b0; end
		endcase
		w = (cfg_width == 0) ? 1 : (cfg_width > PIX_MAX_WIDTH) ? PIX_MAX_WIDTH : int'(cfg_width);
		h = (cfg_height == 0) ? 1 : (cfg_height > ROW_LIMIT) ? ROW_LIMIT : int'(cfg_height);
		gu = grp_u + u8;
		gv = grp_v + v8;
		mask = (1 << hs) - 1;
		if ((pred_col & mask) == mask) begin
			idx = pred_col >> hs;
			if (!two_rows) begin
				word.chroma = 1'b1;
				word.cb = 8'(gu >> hs);
				word.cr = 8'(gv >> hs);
			end else if (pred_row[0] == 1'b0) begin
				if (idx < PIX_MAX_WIDTH)
					upper_sums[idx] = {gv, gu};
			end else begin
				upper = (idx < PIX_MAX_WIDTH) ? upper_sums[idx] : '0;
				pair_u = upper[9:0] + gu;
				pair_v = upper[19:10] + gv;
				word.chroma = 1'b1;
				word.cb = 8'(pair_u >> (hs + 1));
				word.cr = 8'(pair_v >> (hs + 1));
			end
			gu = '0;
			gv = '0;
		end
		word.row_last = (pred_col >= w - 1);
		word.frame_last = word.row_last && (pred_row >= h - 1);
		if (word.row_last) begin
			gu = '0;
			gv = '0;
			pred_col = 0;
			pred_row = word.frame_last ? 0 : pred_row + 1;
		end else begin
			pred_col++;
		end
		grp_u = gu;
		grp_v = gv;
		expected_words.push_back(word);
		pixels_sent++;
	endtask

	// driver sits at a falling edge between calls; in_valid is left to the next call
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		do @(posedge clk); while (in_ready !== 1'b1);
		predict_pixel(r, g, b);
		@(negedge clk);
	endtask

	task automatic send_color(input logic [23:0] rgb);
		send_pixel(rgb[23:16], rgb[15:8], rgb[7:0]);
	endtask

	task automatic send_random_pixel();
		send_pixel(pick_level(), pick_level(), pick_level());
	endtask

	task automatic send_frame();
		do send_random_pixel();
		while (pred_col != 0 || pred_row != 0);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (expected_words.size() != 0);
	endtask

	task automatic set_reg(input cfg_reg_e sel, input int value);
		wait_drained();
		write_enable <= 1'b1;
		reg_index <= sel;
		write_data <= value[CFG_DATA_W-1:0];
		case (sel)
			REG_CHROMA_MODE:  cfg_mode = chroma_mode_e'(value[2:0]);
			REG_IMAGE_WIDTH:  cfg_width = value[11:0];
			REG_IMAGE_HEIGHT: cfg_height = value[12:0];
			default: ;
		endcase
		@(negedge clk);
		write_enable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_format(input chroma_mode_e mode, input int width, input int height);
		set_reg(REG_CHROMA_MODE, mode);
		set_reg(REG_IMAGE_WIDTH, width);
		set_reg(REG_IMAGE_HEIGHT, height);
	endtask

	// reset format, then rows and frames cut short by shrinking the size mid-frame
	task automatic test_defaults_and_shrink();
		for (int i = 0; i < 6; i++)
			send_color(PROBE_COLORS[i]);
		set_reg(REG_IMAGE_WIDTH, 4);
		send_color(PROBE_COLORS[6]);
		set_reg(REG_IMAGE_HEIGHT, 1);
		for (int i = 7; i < 11; i++)
			send_color(PROBE_COLORS[i]);
	endtask

	// 6 x 3 leaves a partial 4-group per row and an unpaired last row
	task automatic test_mode_sweep();
		foreach (ALL_MODES[m]) begin
			set_format(ALL_MODES[m], 6, 3);
			send_frame();
		end
	endtask

	// zero and oversized sizes; long frames are cut short by shrinking the size
	task automatic test_size_limits();
		set_format(MODE_420, 0, 0);
		send_frame();
		send_frame();
		set_format(MODE_422, 4095, 8191);
		repeat (6)
			send_random_pixel();
		set_reg(REG_IMAGE_WIDTH, 1);
		set_reg(REG_IMAGE_HEIGHT, 1);
		send_random_pixel();
		set_format(MODE_440, 1, 8191);
		repeat (5)
			send_random_pixel();
		set_reg(REG_IMAGE_HEIGHT, 1);
		send_random_pixel();
	endtask

	task automatic test_random_frames(input int n_pixels);
		int start;
		start = pixels_sent;
		while (pixels_sent - start < n_pixels) begin
			set_format(chroma_mode_e'($urandom_range(MODE_RSVD_7, MODE_444)),
				($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(12, 1),
				$urandom_range(5));
			repeat ($urandom_range(2, 1))
				send_frame();
		end
	endtask

	task automatic test_output_stall();
		set_format(MODE_420, 8, 4);
		hold_off_left = 300;
		send_frame();
		send_frame();
	endtask

	always @(negedge clk) begin
		if (hold_off_left > 0) begin
			out_ready <= 1'b0;
			hold_off_left = hold_off_left - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	function automatic void check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin : check_words
		yuv_word_t want;
		if (arst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (expected_words.size() == 0) begin
				$error("output word with nothing expected");
				errors++;
			end else begin
				want = expected_words.pop_front();
				check_field("luma", want.luma, luma);
				check_field("chroma_valid", 8'(want.chroma), 8'(chroma_valid));
				check_field("blue_diff", want.cb, blue_diff);
				check_field("red_diff", want.cr, red_diff);
				check_field("row_end", 8'(want.row_last), 8'(row_end));
				check_field("frame_end", 8'(want.frame_last), 8'(frame_end));
			end
		end
	end

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		src_idle_pct = 38;
		sink_idle_pct = 46;
		test_defaults_and_shrink();
		test_mode_sweep();
		test_random_frames(200);
		src_idle_pct = 46;
		sink_idle_pct = 38;
		test_size_limits();
		test_random_frames(200);
		src_idle_pct = 0;
		sink_idle_pct = 0;
		test_output_stall();
		test_random_frames(200);
		wait_drained();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("rgb_to_yuv_chroma_subsampler_top regression: pass");
		else
			$display("rgb_to_yuv_chroma_subsampler_top regression: fail");
		$finish;
	end

	initial begin
		#(5_000_000);
		$display("rgb_to_yuv_chroma_subsampler_top regression: fail");
		$finish;
	end

endmodule
